@@ design/utfd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utfd_pkg
// Shared types and constants for the UTF-8 byte decoder: byte class limits,
// payload masks and the decoder state record.
// ----------------------------------------------------------------------------
package utfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 21;
  localparam int unsigned CntW  = 2;
  localparam int unsigned ContW = 6;

  // Byte class boundaries
  localparam logic [ByteW-1:0] BYTE_ZERO    = 8'h00;
  localparam logic [ByteW-1:0] LEAD_INVALID = 8'hF8;
  localparam logic [ByteW-1:0] LEAD_FOUR    = 8'hF0;
  localparam logic [ByteW-1:0] LEAD_THREE   = 8'hE0;
  localparam logic [ByteW-1:0] LEAD_TWO     = 8'hC0;
  localparam logic [ByteW-1:0] ASCII_MAX    = 8'h7F;
  localparam logic [ByteW-1:0] CONT_MAX     = 8'hBF;

  // Payload masks
  localparam logic [ByteW-1:0] MASK_FOUR  = 8'h07;
  localparam logic [ByteW-1:0] MASK_THREE = 8'h0F;
  localparam logic [ByteW-1:0] MASK_TWO   = 8'h1F;
  localparam logic [ByteW-1:0] MASK_CONT  = 8'h3F;

  // Continuation counts per lead class
  localparam logic [CntW-1:0] NEED_FOUR  = 2'd3;
  localparam logic [CntW-1:0] NEED_THREE = 2'd2;
  localparam logic [CntW-1:0] NEED_TWO   = 2'd1;

  typedef struct packed {
    logic             in_sequence;
    logic [CntW-1:0]  needed_count;
    logic [CntW-1:0]  seen_count;
    logic [CodeW-1:0] accumulator;
  } utfd_state_t;

  localparam utfd_state_t STATE_RESET = '{
    in_sequence:  1'b0,
    needed_count: '0,
    seen_count:   '0,
    accumulator:  '0
  };

endpackage
`default_nettype wire

@@ design/utfd_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utfd_step
// Combinational decoder update: from the current state and one byte, forms
// the next state and the code point given out for that byte.
// ----------------------------------------------------------------------------
module utfd_step (
  input  utfd_pkg::utfd_state_t       state_cur,
  input  logic [utfd_pkg::ByteW-1:0]  byte_cur,
  output utfd_pkg::utfd_state_t       state_nxt,
  output logic [utfd_pkg::CodeW-1:0]  code_nxt
);
  import utfd_pkg::*;

  logic [CodeW-1:0] acc_shift;
  logic [CntW-1:0]  seen_inc;

  // Shift six payload bits into the accumulator, keep 21 bits
  assign acc_shift = {state_cur.accumulator[CodeW-ContW-1:0], byte_cur[ContW-1:0]};
  assign seen_inc  = state_cur.seen_count + CntW'(1);

  always_comb begin
    state_nxt = state_cur;
    code_nxt  = '0;
    priority if (byte_cur == BYTE_ZERO) begin
      // Clear the decoder
      state_nxt = STATE_RESET;
    end else if (!state_cur.in_sequence) begin
      state_nxt.accumulator = '0;
      priority if (byte_cur >= LEAD_INVALID) begin
        // Drop invalid lead
      end else if (byte_cur >= LEAD_FOUR) begin
        state_nxt.accumulator  = CodeW'(byte_cur & MASK_FOUR);
        state_nxt.needed_count = NEED_FOUR;
        state_nxt.seen_count   = '0;
        state_nxt.in_sequence  = 1'b1;
      end else if (byte_cur >= LEAD_THREE) begin
        state_nxt.accumulator  = CodeW'(byte_cur & MASK_THREE);
        state_nxt.needed_count = NEED_THREE;
        state_nxt.seen_count   = '0;
        state_nxt.in_sequence  = 1'b1;
      end else if (byte_cur >= LEAD_TWO) begin
        state_nxt.accumulator  = CodeW'(byte_cur & MASK_TWO);
        state_nxt.needed_count = NEED_TWO;
        state_nxt.seen_count   = '0;
        state_nxt.in_sequence  = 1'b1;
      end else if (byte_cur <= ASCII_MAX) begin
        // Pass ASCII straight through
        code_nxt = CodeW'(byte_cur);
      end else begin
        // Drop stray continuation byte
        state_nxt.seen_count = '0;
      end
    end else begin
      // Take a continuation byte; abort on a byte above the continuation range
      state_nxt.accumulator = acc_shift;
      state_nxt.seen_count  = seen_inc;
      priority if (byte_cur > CONT_MAX) begin
        state_nxt.in_sequence = 1'b0;
      end else if (seen_inc == state_cur.needed_count) begin
        state_nxt.in_sequence = 1'b0;
        code_nxt              = acc_shift;
      end else begin
        // Hold sequence open
      end
    end
  end

endmodule
`default_nettype wire

@@ design/utf8_byte_decoder_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_byte_decoder_core
// Byte-stream UTF-8 decoder: one code point (or zero) per input byte.
// ----------------------------------------------------------------------------
// The decoder takes one byte per clock when not stalled and returns exactly
// one result per byte, in the cycle after the byte is accepted: the
// completed code point, or zero when no character finishes on that byte.
// A zero byte clears any sequence in progress. The rate is one byte per
// cycle while in_stall is low, set by the single register stage that updates
// the decoder state and the result register together; a new byte is accepted
// while a result waits, if the result register is free or is being taken in the same cycle.
module utf8_byte_decoder_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [utfd_pkg::ByteW-1:0]  in_byte_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [utfd_pkg::CodeW-1:0]  out_code_point
);
  import utfd_pkg::*;

  utfd_state_t      state_r;
  utfd_state_t      state_nxt;
  logic [CodeW-1:0] code_nxt;
  logic [CodeW-1:0] out_code_r;
  logic             out_valid_r;
  logic             in_take;

  // Accept a transaction when the result register is free or draining
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  utfd_step u_step (
    .state_cur (state_r),
    .byte_cur  (in_byte_in),
    .state_nxt (state_nxt),
    .code_nxt  (code_nxt)
  );

  // Advance decoder state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      out_code_r <= code_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_code_r;

endmodule
`default_nettype wire
